@@ rtl/bounded_edit_distance_macros.svh @@
`ifndef BOUNDED_EDIT_DISTANCE_MACROS_SVH
`define BOUNDED_EDIT_DISTANCE_MACROS_SVH

// check a property on clk, quiet while arst_n is low
`define BED_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a stalled beat keeps valid and payload
`define BED_HOLD(lbl, vld, rdy, data) \
	`BED_CHECK(lbl, vld && !rdy |=> vld && $stable(data), "stalled beat changed")

`endif

@@ rtl/bed_pkg.sv @@
package bed_pkg;

	localparam logic [1:0] REQ_FIRST   = 2'd0;
	localparam logic [1:0] REQ_SECOND  = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;

	localparam logic [4:0] THR_MAX   = 5'd16;
	localparam logic [4:0] THR_RESET = 5'd2;
	localparam int         DIST_SAT  = 31;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic [4:0] distance;
		logic       over_threshold;
		logic       truncated;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'b001,
		ST_ROWSTART = 3'b010,
		ST_ROW      = 3'b100
	} state_t;

endpackage

@@ rtl/bed_ram.sv @@
module bed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bed_cell.sv @@
module bed_cell #(
	parameter int VW = 6
) (
	input  logic [VW-1:0] above,
	input  logic [VW-1:0] left,
	input  logic [VW-1:0] diag,
	input  logic [7:0]    ch_a,
	input  logic [7:0]    ch_b,
	output logic [VW-1:0] value
);

	logic [VW-1:0] up_cost;
	logic [VW-1:0] left_cost;
	logic [VW-1:0] diag_cost;
	logic [VW-1:0] low2;

	always_comb begin
		up_cost   = above + VW'(1);
		left_cost = left + VW'(1);
		diag_cost = diag + ((ch_a != ch_b) ? VW'(1) : VW'(0));
		low2      = (up_cost < left_cost) ? up_cost : left_cost;
		value     = (low2 < diag_cost) ? low2 : diag_cost;
	end

endmodule

@@ rtl/bounded_edit_distance.sv @@
// Bounded Levenshtein distance between two words of up to MAX_LEN bytes, loaded one
// byte per beat (req_type 0 first word, 1 second word); req_type 2 answers and clears
// both words and the truncated flag. A compute that exits on the length gap or an
// empty word answers at its own accept edge; otherwise the DP walks the first word
// row by row, each row fetching the first-word byte in ST_ROWSTART and then doing one
// read-modify-write of the second-word memory per column in ST_ROW, where the DP row
// sits beside each second-word byte, so the answer is registered after the last row
// and sooner when a row minimum passes the threshold. A compute beat is taken only
// while the result register is empty or draining; loads are taken while a result
// waits. Threshold values above 16 act as 16. No memory clearing pass is needed after
// reset.
module bounded_edit_distance
	import bed_pkg::*;
#(
	parameter int MAX_LEN = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int VW = ((LW > 5) ? LW : 5) + 1;
	localparam int BW = 8 + LW;

	state_t        state_q;
	logic [4:0]    thr_q;
	logic [LW-1:0] len1_q;
	logic [LW-1:0] len2_q;
	logic          ovf_q;
	logic [LW-1:0] i_q;
	logic [AW-1:0] jx_q;
	logic [VW-1:0] left_q;
	logic [VW-1:0] diag_q;
	logic [VW-1:0] rowmin_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [VW-1:0] t_eff;
	logic [VW-1:0] give_up;
	logic [LW-1:0] gap;
	logic          accept;
	logic          slot_free;

	logic          a_we;
	logic [AW-1:0] a_waddr;
	logic          a_re;
	logic [AW-1:0] a_raddr;
	logic [7:0]    a_rdata;
	logic [LW-1:0] i_minus;

	logic          b_we;
	logic [AW-1:0] b_waddr;
	logic [BW-1:0] b_wdata;
	logic          b_re;
	logic [AW-1:0] b_raddr;
	logic [BW-1:0] b_rdata;
	logic [7:0]    b_ch;
	logic [LW-1:0] b_dp;

	logic [LW-1:0] j_cur;
	logic          last_col;
	logic [VW-1:0] above;
	logic [VW-1:0] cell_v;
	logic [VW-1:0] rowmin_n;

	logic          finish;
	logic [VW-1:0] result;

	assign t_eff     = (thr_q > THR_MAX) ? VW'(THR_MAX) : VW'(thr_q);
	assign give_up   = t_eff + VW'(1);
	assign gap       = (len1_q > len2_q) ? (len1_q - len2_q) : (len2_q - len1_q);
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && ((req.req_type != REQ_COMPUTE) || slot_free);
	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;

	assign i_minus = i_q - LW'(1);
	assign j_cur   = LW'(jx_q) + LW'(1);
	assign last_col = (j_cur == len2_q);
	assign b_ch    = b_rdata[BW-1 -: 8];
	assign b_dp    = b_rdata[LW-1:0];
	assign above   = (i_q == LW'(1)) ? VW'(j_cur) : VW'(b_dp);
	assign rowmin_n = (cell_v < rowmin_q) ? cell_v : rowmin_q;

	always_comb begin
		a_we    = accept && (req.req_type == REQ_FIRST) && (len1_q < LW'(MAX_LEN));
		a_waddr = len1_q[AW-1:0];
		a_re    = (state_q == ST_ROWSTART);
		a_raddr = i_minus[AW-1:0];
		b_we    = 1'b0;
		b_waddr = len2_q[AW-1:0];
		b_wdata = {req.char_code, LW'(0)};
		b_re    = 1'b0;
		b_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				b_we = accept && (req.req_type == REQ_SECOND) && (len2_q < LW'(MAX_LEN));
			end
			ST_ROWSTART: begin
				b_re = 1'b1;
			end
			ST_ROW: begin
				b_we    = 1'b1;
				b_waddr = jx_q;
				b_wdata = {b_ch, cell_v[LW-1:0]};
				b_re    = !last_col;
				b_raddr = jx_q + AW'(1);
			end
			default: begin
				b_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		finish = 1'b0;
		result = give_up;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.req_type == REQ_COMPUTE)) begin
					if (VW'(gap) > t_eff) begin
						finish = 1'b1;
					end else if (len1_q == '0) begin
						finish = 1'b1;
						result = VW'(len2_q);
					end else if (len2_q == '0) begin
						finish = 1'b1;
					end
				end
			end
			ST_ROW: begin
				if (last_col) begin
					if (rowmin_n > t_eff) begin
						finish = 1'b1;
					end else if (i_q == len1_q) begin
						finish = 1'b1;
						result = cell_v;
					end
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	bed_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LEN)
	) u_first (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (req.char_code),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	bed_ram #(
		.WIDTH (BW),
		.DEPTH (MAX_LEN)
	) u_second (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	bed_cell #(
		.VW (VW)
	) u_cell (
		.above (above),
		.left  (left_q),
		.diag  (diag_q),
		.ch_a  (a_rdata),
		.ch_b  (b_ch),
		.value (cell_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			len1_q      <= '0;
			len2_q      <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			jx_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_FIRST: begin
								if (len1_q < LW'(MAX_LEN)) begin
									len1_q <= len1_q + LW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							REQ_SECOND: begin
								if (len2_q < LW'(MAX_LEN)) begin
									len2_q <= len2_q + LW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							REQ_COMPUTE: begin
								if (!finish) begin
									i_q     <= LW'(1);
									state_q <= ST_ROWSTART;
								end
							end
							default: begin
								ovf_q <= ovf_q;
							end
						endcase
					end
				end
				ST_ROWSTART: begin
					jx_q    <= '0;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (!last_col) begin
						jx_q <= jx_q + AW'(1);
					end else if (!finish) begin
						i_q     <= i_q + LW'(1);
						state_q <= ST_ROWSTART;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				rsp_valid_q <= 1'b1;
				len1_q      <= '0;
				len2_q      <= '0;
				ovf_q       <= 1'b0;
				state_q     <= ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROWSTART) begin
			left_q   <= VW'(i_q);
			diag_q   <= VW'(i_minus);
			rowmin_q <= give_up;
		end else if (state_q == ST_ROW) begin
			left_q   <= cell_v;
			diag_q   <= above;
			rowmin_q <= rowmin_n;
		end
		if (finish) begin
			rsp_q.distance       <= (result > VW'(DIST_SAT)) ? 5'(DIST_SAT) : result[4:0];
			rsp_q.over_threshold <= (result > t_eff);
			rsp_q.truncated      <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/bed_checker.sv @@
`include "bounded_edit_distance_macros.svh"

module bed_checker
	import bed_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp,
	input logic cfg_valid,
	input logic cfg_ready
);

	logic cmp_beat;
	logic load_beat;

	assign cmp_beat  = req_valid && req_ready && (req.req_type == REQ_COMPUTE);
	assign load_beat = req_valid && req_ready && (req.req_type != REQ_COMPUTE);

	`BED_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp)
	`BED_CHECK(a_no_overwrite, cmp_beat |-> !rsp_valid || rsp_ready, "compute over waiting result")
	`BED_CHECK(a_load_no_rsp, load_beat |=> !$rose(rsp_valid), "result without compute")
	`BED_CHECK(a_over_nonzero, rsp_valid && rsp.over_threshold |-> rsp.distance != 5'd0, "over at zero")
	`BED_CHECK(a_cfg_taken, cfg_valid |-> cfg_ready, "config beat stalled")

endmodule

bind bounded_edit_distance bed_checker u_bed_checker (.*);

@@ dv/tb_top.sv @@
module tb_top;
	import bed_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = 16;
	localparam int SETTLE = MAX_LEN * (MAX_LEN + 1) + 32;
	localparam int LONG_HOLD = 400;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [4:0] cfg_data = '0;

	req_t beats_to_send[$];
	rsp_t pending_answers[$];
	int beats_queued = 0;
	int beats_taken = 0;
	int work_beats = 0;
	int errors = 0;
	int send_gap_pct = 23;
	int recv_gap_pct = 23;
	int hold_epoch = 0;
	int seen_epoch = 0;
	int hold_left = 0;

	logic [7:0] word_a[MAX_LEN];
	logic [7:0] word_b[MAX_LEN];
	int len_a = 0;
	int len_b = 0;
	bit overflow_model = 1'b0;
	logic [4:0] thr_model = THR_RESET;

	bounded_edit_distance #(
		.MAX_LEN(MAX_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int predict_distance();
		int lim, gap, diag, above, v, row_low;
		int row[MAX_LEN + 1];
		bit same;
		lim = (thr_model > THR_MAX) ? int'(THR_MAX) : int'(thr_model);
		gap = (len_a > len_b) ? len_a - len_b : len_b - len_a;
		if (gap > lim)
			return lim + 1;
		same = (len_a == len_b);
		if (same)
			for (int k = 0; k < len_a; k++)
				if (word_a[k] != word_b[k])
					same = 1'b0;
		if (same)
			return 0;
		for (int j = 0; j <= len_b; j++)
			row[j] = j;
		for (int i = 1; i <= len_a; i++) begin
			diag = row[0];
			row_low = lim + 1;
			row[0] = i;
			for (int j = 1; j <= len_b; j++) begin
				above = row[j];
				v = above + 1;
				if (row[j - 1] + 1 < v)
					v = row[j - 1] + 1;
				if (diag + ((word_a[i - 1] == word_b[j - 1]) ? 0 : 1) < v)
					v = diag + ((word_a[i - 1] == word_b[j - 1]) ? 0 : 1);
				diag = above;
				row[j] = v;
				if (v < row_low)
					row_low = v;
			end
			if (row_low > lim)
				return lim + 1;
		end
		return row[len_b];
	endfunction

	// request driver: present queued beats, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		int d, lim;
		rsp_t answer;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				beats_taken++;
				case (req.req_type)
					REQ_FIRST: begin
						if (len_a < MAX_LEN) begin
							word_a[len_a] = req.char_code;
							len_a++;
						end else begin
							overflow_model = 1'b1;
						end
					end
					REQ_SECOND: begin
						if (len_b < MAX_LEN) begin
							word_b[len_b] = req.char_code;
							len_b++;
						end else begin
							overflow_model = 1'b1;
						end
					end
					REQ_COMPUTE: begin
						d = predict_distance();
						lim = (thr_model > THR_MAX) ? int'(THR_MAX) : int'(thr_model);
						answer.distance = (d > DIST_SAT) ? 5'(DIST_SAT) : d[4:0];
						answer.over_threshold = (d > lim);
						answer.truncated = overflow_model;
						pending_answers.push_back(answer);
						len_a = 0;
						len_b = 0;
						overflow_model = 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (!req_valid || req_ready) begin
				if (beats_to_send.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					req <= beats_to_send.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and ready generator
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_answers.size() == 0) begin
					$display("%0t: unexpected beat distance %0d over %0b truncated %0b",
						$time, rsp.distance, rsp.over_threshold, rsp.truncated);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					if (rsp !== want) begin
						$display("%0t: expected distance %0d over %0b truncated %0b,",
							$time, want.distance, want.over_threshold, want.truncated,
							" got %0d %0b %0b",
							rsp.distance, rsp.over_threshold, rsp.truncated);
						errors++;
					end
				end
			end
			if (hold_epoch != seen_epoch) begin
				seen_epoch = hold_epoch;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
			end
		end
	end

	task automatic push_beat(input logic [1:0] kind, input logic [7:0] ch);
		req_t b;
		b.req_type = kind;
		b.char_code = ch;
		beats_to_send.push_back(b);
		beats_queued++;
		if (kind != REQ_UNUSED)
			work_beats++;
	endtask

	function automatic logic [7:0] pick_char(input bit narrow);
		return narrow ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
	endfunction

	task automatic queue_pair();
		logic [7:0] wa[$];
		logic [7:0] wb[$];
		int na, pos, ia, ib;
		bit narrow;
		narrow = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 14) == 0)
			push_beat(REQ_COMPUTE, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			na = $urandom_range(MAX_LEN, MAX_LEN + 3);
		else
			na = $urandom_range(0, 8);
		repeat (na) wa.push_back(pick_char(narrow));
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(0, MAX_LEN)) wb.push_back(pick_char(narrow));
		end else begin
			wb = wa;
			repeat ($urandom_range(0, 4)) begin
				pos = $urandom_range(0, wb.size());
				case ($urandom_range(0, 2))
					0: wb.insert(pos, pick_char(narrow));
					1: if (pos < wb.size()) wb.delete(pos);
					default: if (pos < wb.size()) wb[pos] = pick_char(narrow);
				endcase
			end
		end
		ia = 0;
		ib = 0;
		while (ia < wa.size() || ib < wb.size()) begin
			if ($urandom_range(0, 19) == 0)
				push_beat(REQ_UNUSED, 8'($urandom_range(0, 255)));
			if (ib >= wb.size() || (ia < wa.size() && $urandom_range(0, 1))) begin
				push_beat(REQ_FIRST, wa[ia]);
				ia++;
			end else begin
				push_beat(REQ_SECOND, wb[ib]);
				ib++;
			end
		end
		push_beat(REQ_COMPUTE, 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		while (beats_taken != beats_queued || pending_answers.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [4:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		thr_model = value;
	endtask

	initial begin
		logic [4:0] thr_plan[6];
		int start;
		thr_plan = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd7, 5'd4};
		thr_plan[5] = 5'($urandom_range(0, 31));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_threshold(THR_RESET);

		push_beat(REQ_COMPUTE, 8'h00);
		push_beat(REQ_SECOND, 8'h61);
		push_beat(REQ_SECOND, 8'h62);
		push_beat(REQ_COMPUTE, 8'hFF);
		push_beat(REQ_FIRST, 8'h78);
		push_beat(REQ_COMPUTE, 8'h00);
		push_beat(REQ_FIRST, 8'h61);
		push_beat(REQ_FIRST, 8'h62);
		push_beat(REQ_SECOND, 8'h61);
		push_beat(REQ_SECOND, 8'h62);
		push_beat(REQ_COMPUTE, 8'h00);
		push_beat(REQ_UNUSED, 8'hFF);
		push_beat(REQ_FIRST, 8'h00);
		push_beat(REQ_FIRST, 8'hFF);
		push_beat(REQ_SECOND, 8'hFF);
		push_beat(REQ_SECOND, 8'h00);
		push_beat(REQ_COMPUTE, 8'h00);
		push_beat(REQ_FIRST, 8'h61);
		push_beat(REQ_FIRST, 8'h62);
		push_beat(REQ_FIRST, 8'h63);
		push_beat(REQ_FIRST, 8'h64);
		push_beat(REQ_SECOND, 8'h61);
		push_beat(REQ_COMPUTE, 8'h00);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_threshold(thr_plan[p]);
			send_gap_pct = (p == 2 || p == 3) ? 0 : 23;
			recv_gap_pct = (p == 2) ? 0 : 23;
			if (p == 3)
				hold_epoch++;
			start = work_beats;
			while (work_beats - start < 55)
				queue_pair();
			drain();
		end

		if (errors == 0 && pending_answers.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bed_pkg.sv
rtl/bed_ram.sv
rtl/bed_cell.sv
rtl/bounded_edit_distance.sv
rtl/bed_checker.sv
dv/tb_top.sv
